// ===== rtl/esckd_pkg.sv =====
// Shared types and constants for the escape sequence key decoder.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package esckd_pkg;

  // Widths of the byte and key fields
  localparam int ByteW = 8;
  localparam int KeyW  = 10;
  localparam int MagW  = 9;

  // Input bytes with special meaning
  localparam logic [ByteW-1:0] ChEsc    = 8'd27;
  localparam logic [ByteW-1:0] ChLead1  = 8'd194;
  localparam logic [ByteW-1:0] ChLead2  = 8'd195;
  localparam logic [ByteW-1:0] ChCsi    = 8'd91;
  localparam logic [ByteW-1:0] ChSs3    = 8'd79;
  localparam logic [ByteW-1:0] ChOne    = 8'd49;
  localparam logic [ByteW-1:0] ChTwo    = 8'd50;
  localparam logic [ByteW-1:0] ChThree  = 8'd51;
  localparam logic [ByteW-1:0] ChFive   = 8'd53;
  localparam logic [ByteW-1:0] ChSix    = 8'd54;
  localparam logic [ByteW-1:0] ChTilde  = 8'd126;

  // Magnitude arithmetic constants
  localparam logic [MagW-1:0] Csi1Base  = 9'd62;
  localparam logic [MagW-1:0] Csi1Hit   = 9'd115;
  localparam logic [MagW-1:0] Csi1Fix   = 9'd116;
  localparam logic [MagW-1:0] Csi2Base  = 9'd71;
  localparam logic [MagW-1:0] Csi2Limit = 9'd121;
  localparam logic [KeyW-1:0] Ss3Base   = 10'd32;
  localparam logic [KeyW-1:0] InsertMag = 10'd45;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_CSI1  = 3'd3,
    PH_CSI2  = 3'd4,
    PH_TRAIL = 3'd5,
    PH_SS3   = 3'd6
  } phase_t;

  // Raw decoded key from the parser, before remapping
  typedef struct packed {
    logic            emit;
    logic [KeyW-1:0] key;
  } raw_key_t;

  // Final key after remapping and control-code drop
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] code;
  } key_out_t;

endpackage

// ===== rtl/esckd_parse.sv =====
// Escape sequence parser: phase and pending magnitude registers plus
// next-state logic. Depends on esckd_pkg.
`timescale 1ns / 1ps

module esckd_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,      // one byte is consumed this cycle
  input  logic [esckd_pkg::ByteW-1:0] in_byte,
  output esckd_pkg::raw_key_t         raw
);

  esckd_pkg::phase_t                phase, phase_next;
  logic [esckd_pkg::MagW-1:0]       pend, pend_next;
  logic [esckd_pkg::MagW-1:0]       mag1, mag2;
  logic [esckd_pkg::KeyW-1:0]       neg_byte;

  // Candidate magnitudes for the CSI 1 and CSI 2 paths
  always_comb begin
    mag1 = esckd_pkg::Csi1Base + {1'b0, in_byte};
    if (mag1 == esckd_pkg::Csi1Hit) begin
      mag1 = esckd_pkg::Csi1Fix;
    end
    mag2 = esckd_pkg::Csi2Base + {1'b0, in_byte};
    if (mag2 < esckd_pkg::Csi2Limit) begin
      mag2 = mag2 + 9'd1;
    end
  end

  assign neg_byte = 10'd0 - {2'b00, in_byte};

  // Next phase, pending magnitude and raw key
  always_comb begin
    phase_next = phase;
    pend_next  = pend;
    raw.emit   = 1'b0;
    raw.key    = '0;
    case (phase)
      esckd_pkg::PH_ESC: begin
        if (in_byte == esckd_pkg::ChCsi) begin
          phase_next = esckd_pkg::PH_CSI;
        end else if (in_byte == esckd_pkg::ChSs3) begin
          phase_next = esckd_pkg::PH_SS3;
        end else begin
          raw.emit = 1'b1;
          raw.key  = neg_byte;
        end
      end
      esckd_pkg::PH_SS3: begin
        raw.emit = 1'b1;
        raw.key  = 10'd0 - (esckd_pkg::Ss3Base + {2'b00, in_byte});
      end
      esckd_pkg::PH_CSI: begin
        if (in_byte == esckd_pkg::ChOne) begin
          phase_next = esckd_pkg::PH_CSI1;
        end else if (in_byte == esckd_pkg::ChTwo) begin
          phase_next = esckd_pkg::PH_CSI2;
        end else if (in_byte == esckd_pkg::ChThree || in_byte == esckd_pkg::ChFive ||
                     in_byte == esckd_pkg::ChSix) begin
          pend_next  = {1'b0, in_byte};
          phase_next = esckd_pkg::PH_TRAIL;
        end else begin
          raw.emit = 1'b1;
          raw.key  = neg_byte;
        end
      end
      esckd_pkg::PH_CSI1: begin
        pend_next  = mag1;
        phase_next = esckd_pkg::PH_TRAIL;
      end
      esckd_pkg::PH_CSI2: begin
        if (in_byte == esckd_pkg::ChTilde) begin
          raw.emit = 1'b1;
          raw.key  = 10'd0 - esckd_pkg::InsertMag;
        end else begin
          pend_next  = mag2;
          phase_next = esckd_pkg::PH_TRAIL;
        end
      end
      esckd_pkg::PH_TRAIL: begin
        // trailing byte is discarded unchecked
        raw.emit = 1'b1;
        raw.key  = 10'd0 - {1'b0, pend};
      end
      default: begin
        if (in_byte == esckd_pkg::ChEsc || in_byte == esckd_pkg::ChLead1 ||
            in_byte == esckd_pkg::ChLead2) begin
          phase_next = esckd_pkg::PH_ESC;
          pend_next  = '0;
        end else begin
          raw.emit = 1'b1;
          raw.key  = {2'b00, in_byte};
        end
      end
    endcase
    // any emitted key closes the sequence
    if (raw.emit) begin
      phase_next = esckd_pkg::PH_IDLE;
      pend_next  = '0;
    end
  end

  // Advance the parser state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= esckd_pkg::PH_IDLE;
      pend  <= '0;
    end else if (en) begin
      phase <= phase_next;
      pend  <= pend_next;
    end
  end

endmodule

// ===== rtl/esckd_remap.sv =====
// Key remap table and control-code filter for the escape sequence key
// decoder. Purely combinational. Depends on esckd_pkg.
`timescale 1ns / 1ps

module esckd_remap (
  input  esckd_pkg::raw_key_t raw,
  output esckd_pkg::key_out_t res
);

  logic signed [esckd_pkg::KeyW-1:0] k;
  logic signed [esckd_pkg::KeyW-1:0] r;
  logic                              drop;

  assign k = signed'(raw.key);

  // Map special keys to editor codes
  always_comb begin
    r = k;
    case (k)
      10'sd127:  r = 10'sd8;
      -10'sd27:  r = 10'sd27;
      -10'sd51:  r = 10'sd127;
      -10'sd164: r = 10'sd132;
      -10'sd182: r = 10'sd148;
      -10'sd188: r = 10'sd129;
      -10'sd132: r = 10'sd142;
      -10'sd150: r = 10'sd153;
      -10'sd156: r = 10'sd154;
      -10'sd159: r = 10'sd225;
      -10'sd181: r = 10'sd230;
      -10'sd167: r = 10'sd245;
      -10'sd176: r = 10'sd248;
      -10'sd178: r = 10'sd253;
      -10'sd179: r = 10'sd252;
      -10'sd180: r = 10'sd239;
      -10'sd65:  r = -10'sd38;
      -10'sd66:  r = -10'sd40;
      -10'sd68:  r = -10'sd37;
      -10'sd67:  r = -10'sd39;
      -10'sd53:  r = -10'sd33;
      -10'sd54:  r = -10'sd34;
      -10'sd72:  r = -10'sd36;
      -10'sd70:  r = -10'sd35;
      default:   r = k;
    endcase
  end

  // Drop control codes other than tab and line feed
  assign drop = (k >= 10'sd0 && k <= 10'sd8) || (k >= 10'sd11 && k <= 10'sd26);

  assign res.valid = raw.emit && !drop;
  assign res.code  = unsigned'(r);

endmodule

// ===== rtl/escape_sequence_key_decoder.sv =====
// Top level of the escape sequence key decoder: input register, parser,
// remap and output register. Depends on esckd_pkg, esckd_parse, esckd_remap.
`timescale 1ns / 1ps

// Terminal byte to editor key decoder.
// Input: one raw terminal byte per transfer on s_tvalid/s_tready/s_tdata.
// Output: one signed 10-bit key code per transfer on m_tvalid/m_tready/
// m_tdata. Bytes that open or continue an escape sequence, and dropped
// control codes, give no output transfer; every other byte gives exactly one.
// The byte that completes a key passes the input register, then the parse
// and remap logic into the output register, before the key is valid there.
// Throughput: one byte per cycle while the output is not stalled; the
// output register lets a new byte enter while a key waits.
// When the receiver holds m_tready low with a key pending, the pipeline
// freezes and s_tready drops once the input register is full; nothing is
// lost or reordered.
// Reset (rst, synchronous) empties both registers and returns the parser to
// idle with no escape pending.
module escape_sequence_key_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [9:0] key_code (signed), [15:10] zero
);

  logic                        in_valid;
  logic [esckd_pkg::ByteW-1:0] in_byte;
  logic                        adv;
  logic [esckd_pkg::KeyW-1:0]  key_code;
  esckd_pkg::raw_key_t         raw;
  esckd_pkg::key_out_t         res;

  // Move the pipeline when the output register is free or being taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  esckd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .en      (adv && in_valid),
    .in_byte (in_byte),
    .raw     (raw)
  );

  esckd_remap u_remap (
    .raw (raw),
    .res (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid && res.valid) begin
      key_code <= res.code;
    end
  end

  assign m_tdata = {6'd0, key_code};

endmodule

// ===== verif/tb_escape_sequence_key_decoder.sv =====
// Self-checking testbench for escape_sequence_key_decoder: a directed table
// followed by random escape sequences, checked against a built-in predictor.
// Depends on esckd_pkg and the escape_sequence_key_decoder RTL.
`timescale 1ns / 1ps

module tb_escape_sequence_key_decoder;

  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,  // expected key comes from the predictor
    ROW_KEY     = 2'd1,  // expected key typed into the table
    ROW_SILENT  = 2'd2   // no key expected from this byte
  } row_kind_t;

  typedef struct {
    logic [7:0] b;
    row_kind_t  kind;
    int         key;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // [9:0] key_code (signed), [15:10] zero

  // Predictor state
  esckd_pkg::phase_t parse_ph = esckd_pkg::PH_IDLE;
  logic [8:0]        held_mag = '0;

  // Expected keys, oldest first
  logic [9:0]  key_expect_q[$];
  logic [9:0]  want_key;

  int          mismatches = 0;
  int          bytes_sent = 0;
  int          keys_seen  = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Directed bytes; typed keys are written straight into the table
  stim_row_t dir_rows [28] = '{
    '{8'd0,               ROW_SILENT, 0},     // plain NUL is a dropped control code
    '{8'd255,             ROW_KEY,    255},
    '{8'd127,             ROW_KEY,    8},     // DEL maps to backspace
    '{esckd_pkg::ChEsc,   ROW_SILENT, 0},     // escape followed by zero: dropped
    '{8'd0,               ROW_SILENT, 0},
    '{esckd_pkg::ChEsc,   ROW_SILENT, 0},     // escape byte inside a sequence
    '{esckd_pkg::ChEsc,   ROW_KEY,    27},
    '{esckd_pkg::ChLead1, ROW_SILENT, 0},     // CSI 2 with a non-tilde byte
    '{esckd_pkg::ChCsi,   ROW_SILENT, 0},
    '{esckd_pkg::ChTwo,   ROW_SILENT, 0},
    '{8'd40,              ROW_SILENT, 0},
    '{8'd7,               ROW_PREDICT, 0},
    '{esckd_pkg::ChLead2, ROW_SILENT, 0},     // SS3 at the top byte value
    '{esckd_pkg::ChSs3,   ROW_SILENT, 0},
    '{8'd255,             ROW_KEY,    -287},
    '{esckd_pkg::ChEsc,   ROW_SILENT, 0},     // CSI 1 at the top byte value
    '{esckd_pkg::ChCsi,   ROW_SILENT, 0},
    '{esckd_pkg::ChOne,   ROW_SILENT, 0},
    '{8'd255,             ROW_SILENT, 0},
    '{8'd0,               ROW_KEY,    -317},
    '{esckd_pkg::ChEsc,   ROW_SILENT, 0},     // insert key
    '{esckd_pkg::ChCsi,   ROW_SILENT, 0},
    '{esckd_pkg::ChTwo,   ROW_SILENT, 0},
    '{esckd_pkg::ChTilde, ROW_KEY,    -45},
    '{esckd_pkg::ChEsc,   ROW_SILENT, 0},     // delete key, any trailer value
    '{esckd_pkg::ChCsi,   ROW_SILENT, 0},
    '{esckd_pkg::ChThree, ROW_SILENT, 0},
    '{8'd255,             ROW_KEY,    127}
  };

  escape_sequence_key_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Map a decoded key to the editor key code
  function automatic int remap_key(input int k);
    case (k)
      127:  return 8;
      -27:  return 27;
      -51:  return 127;
      -164: return 132;
      -182: return 148;
      -188: return 129;
      -132: return 142;
      -150: return 153;
      -156: return 154;
      -159: return 225;
      -181: return 230;
      -167: return 245;
      -176: return 248;
      -178: return 253;
      -179: return 252;
      -180: return 239;
      -65:  return -38;
      -66:  return -40;
      -68:  return -37;
      -67:  return -39;
      -53:  return -33;
      -54:  return -34;
      -72:  return -36;
      -70:  return -35;
      default: return k;
    endcase
  endfunction

  // Advance the parser by one byte; report whether a key code comes out
  function automatic void predict_key(input logic [7:0] b, output logic hit,
                                      output logic [9:0] code);
    int         raw;
    logic       done;
    logic [8:0] m;
    raw  = 0;
    done = 1'b0;
    hit  = 1'b0;
    code = '0;
    case (parse_ph)
      esckd_pkg::PH_ESC: begin
        if (b == esckd_pkg::ChCsi) parse_ph = esckd_pkg::PH_CSI;
        else if (b == esckd_pkg::ChSs3) parse_ph = esckd_pkg::PH_SS3;
        else begin
          raw = -int'(b);
          done = 1'b1;
        end
      end
      esckd_pkg::PH_SS3: begin
        raw = -(int'(esckd_pkg::Ss3Base) + int'(b));
        done = 1'b1;
      end
      esckd_pkg::PH_CSI: begin
        if (b == esckd_pkg::ChOne) parse_ph = esckd_pkg::PH_CSI1;
        else if (b == esckd_pkg::ChTwo) parse_ph = esckd_pkg::PH_CSI2;
        else if (b == esckd_pkg::ChThree || b == esckd_pkg::ChFive ||
                 b == esckd_pkg::ChSix) begin
          held_mag = {1'b0, b};
          parse_ph = esckd_pkg::PH_TRAIL;
        end else begin
          raw = -int'(b);
          done = 1'b1;
        end
      end
      esckd_pkg::PH_CSI1: begin
        m = esckd_pkg::Csi1Base + {1'b0, b};
        if (m == esckd_pkg::Csi1Hit) m = esckd_pkg::Csi1Fix;
        held_mag = m;
        parse_ph = esckd_pkg::PH_TRAIL;
      end
      esckd_pkg::PH_CSI2: begin
        if (b == esckd_pkg::ChTilde) begin
          raw = -int'(esckd_pkg::InsertMag);
          done = 1'b1;
        end else begin
          m = esckd_pkg::Csi2Base + {1'b0, b};
          if (m < esckd_pkg::Csi2Limit) m = m + 9'd1;
          held_mag = m;
          parse_ph = esckd_pkg::PH_TRAIL;
        end
      end
      esckd_pkg::PH_TRAIL: begin
        raw = -int'(held_mag);
        done = 1'b1;
      end
      default: begin
        if (b == esckd_pkg::ChEsc || b == esckd_pkg::ChLead1 ||
            b == esckd_pkg::ChLead2) begin
          parse_ph = esckd_pkg::PH_ESC;
          held_mag = '0;
        end else begin
          raw = int'(b);
          done = 1'b1;
        end
      end
    endcase
    if (done) begin
      parse_ph = esckd_pkg::PH_IDLE;
      held_mag = '0;
      // Control bytes other than tab and newline never reach the editor
      hit  = !((raw >= 0 && raw <= 8) || (raw >= 11 && raw <= 26));
      code = 10'(remap_key(raw));
    end
  endfunction

  // Offer one byte, hold it until the transfer, then record what it should yield
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind, input int key);
    logic       hit;
    logic [9:0] code;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    predict_key(b, hit, code);
    case (kind)
      ROW_PREDICT: if (hit) key_expect_q.push_back(code);
      ROW_KEY:     key_expect_q.push_back(10'(key));
      default:     ;
    endcase
  endtask

  // Build one random sequence, mostly well formed with random content
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic [7:0] lead;
    int         pick;
    case ($urandom_range(2))
      0:       lead = esckd_pkg::ChEsc;
      1:       lead = esckd_pkg::ChLead1;
      default: lead = esckd_pkg::ChLead2;
    endcase
    pick = $urandom_range(9);
    case (pick)
      0, 1: seq = {8'($urandom_range(255))};
      2:    seq = {lead, 8'($urandom_range(255))};
      3:    seq = {lead, esckd_pkg::ChSs3, 8'($urandom_range(255))};
      4:    seq = {lead, esckd_pkg::ChCsi, 8'($urandom_range(255))};
      5:    seq = {lead, esckd_pkg::ChCsi, esckd_pkg::ChOne,
                   8'($urandom_range(255)), 8'($urandom_range(255))};
      6: begin
        seq = {lead, esckd_pkg::ChCsi, esckd_pkg::ChTwo};
        if ($urandom_range(1) == 0) seq.push_back(esckd_pkg::ChTilde);
        else begin
          seq.push_back(8'($urandom_range(255)));
          seq.push_back(8'($urandom_range(255)));
        end
      end
      7: begin
        case ($urandom_range(2))
          0:       seq = {lead, esckd_pkg::ChCsi, esckd_pkg::ChThree};
          1:       seq = {lead, esckd_pkg::ChCsi, esckd_pkg::ChFive};
          default: seq = {lead, esckd_pkg::ChCsi, esckd_pkg::ChSix};
        endcase
        seq.push_back(8'($urandom_range(255)));
      end
      8:    seq = {lead, esckd_pkg::ChCsi, 8'($urandom_range(65, 72))};
      default: begin
        // Broken sequence: a lead byte and a few random bytes
        seq = {lead};
        repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(255)));
      end
    endcase
    foreach (seq[i]) send_byte(seq[i], ROW_PREDICT, 0);
  endtask

  // Stop offering bytes and wait for every outstanding key, with a limit
  task automatic wait_for_keys();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (key_expect_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    // Let a dropped byte still in the pipeline retire
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each output transfer with the oldest expected key
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      keys_seen++;
      if (key_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected key code %0d", $realtime,
                   $signed(m_tdata[9:0]));
      end else begin
        want_key = key_expect_q.pop_front();
        if (m_tdata !== {6'b0, want_key}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: key_code expected %0d (tdata %h), got %0d (tdata %h)",
                     $realtime, $signed(want_key), {6'b0, want_key},
                     $signed(m_tdata[9:0]), m_tdata);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with no idling
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].kind, dir_rows[i].key);
    wait_for_keys();

    // Random sequences under four idle/stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 6;  rx_stall_pct = 6;  end
      endcase
      // Back up the output so the block fills and stalls its input
      if (p == 0) hold_reqs <= hold_reqs + 1;
      target = bytes_sent + 225;
      while (bytes_sent < target) send_sequence();
      wait_for_keys();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d terminal bytes (%0d from the directed table) and %0d key codes,",
             bytes_sent, $size(dir_rows), keys_seen);
    $display("across CSI, SS3, plain and broken sequences under four idle/stall mixes.");
    if (mismatches == 0 && key_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (key_expect_q.size() != 0)
        $display("%0d expected key codes never arrived", key_expect_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timed out waiting for the decoder");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/esckd_pkg.sv
rtl/esckd_parse.sv
rtl/esckd_remap.sv
rtl/escape_sequence_key_decoder.sv
verif/tb_escape_sequence_key_decoder.sv
